>>> hw/rtl/cdfq_pkg.sv
package cdfq_pkg;

  // defaults for the top-level parameters
  localparam int MAX_LEN_DEF   = 64;
  localparam int DATA_BITS_DEF = 18;

  // configuration port
  localparam int LEN_BITS      = 7;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 7;

  localparam logic [CFG_IDX_BITS-1:0] CFG_DIRECTION   = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LINE_LENGTH = 1'd1;

  localparam logic [LEN_BITS-1:0] LINE_LENGTH_RST = 7'd64;
  localparam logic [LEN_BITS-1:0] LEN_MIN         = 7'd4;

  // shared ALU operations
  typedef logic [1:0] alu_op_t;
  localparam alu_op_t OP_HI    = 2'd0;  // a - floor((b + c) / 2)
  localparam alu_op_t OP_LO    = 2'd1;  // a + floor((b + c) / 4)
  localparam alu_op_t OP_ODD   = 2'd2;  // 2a + floor((b + c) / 2)
  localparam alu_op_t OP_QUANT = 2'd3;  // a / 2, toward zero

  typedef struct packed {
    logic start;
    logic inverse;
  } seq_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } seq_stat_t;

endpackage

>>> hw/rtl/cdfq_ram.sv
module cdfq_ram #(
  parameter int WIDTH = cdfq_pkg::DATA_BITS_DEF,
  parameter int DEPTH = cdfq_pkg::MAX_LEN_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/cdfq_alu.sv
module cdfq_alu #(
  parameter int DATA_BITS = cdfq_pkg::DATA_BITS_DEF
) (
  input  cdfq_pkg::alu_op_t            op,
  input  logic signed [DATA_BITS+1:0]  a,
  input  logic signed [DATA_BITS+1:0]  b,
  input  logic signed [DATA_BITS+1:0]  c,
  output logic signed [DATA_BITS+1:0]  y,
  output logic signed [DATA_BITS-1:0]  y_sat
);

  localparam int W  = DATA_BITS + 2;
  localparam int WI = W + 2;

  logic signed [WI-1:0] ae;
  logic signed [WI-1:0] be;
  logic signed [WI-1:0] ce;
  logic signed [WI-1:0] sum;
  logic signed [WI-1:0] rnd;
  logic signed [WI-1:0] t;
  logic signed [WI-1:0] r;
  logic                 in_range;

  always_comb begin
    ae  = $signed({{2{a[W-1]}}, a});
    be  = $signed({{2{b[W-1]}}, b});
    ce  = $signed({{2{c[W-1]}}, c});
    sum = be + ce;
    rnd = $signed({{(WI-1){1'b0}}, a[W-1]});
    t   = ae + rnd;
    unique case (op)
      cdfq_pkg::OP_HI:    r = ae - (sum >>> 1);
      cdfq_pkg::OP_LO:    r = ae + (sum >>> 2);
      cdfq_pkg::OP_ODD:   r = (ae <<< 1) + (sum >>> 1);
      cdfq_pkg::OP_QUANT: r = t >>> 1;
    endcase
  end

  assign y = r[W-1:0];

  // in range when all bits above the result's sign match it
  assign in_range = (&r[WI-1:DATA_BITS-1]) || ~(|r[WI-1:DATA_BITS-1]);

  always_comb begin
    if (in_range) begin
      y_sat = r[DATA_BITS-1:0];
    end else if (r[WI-1]) begin
      y_sat = $signed({1'b1, {(DATA_BITS-1){1'b0}}});
    end else begin
      y_sat = $signed({1'b0, {(DATA_BITS-1){1'b1}}});
    end
  end

endmodule

>>> hw/rtl/cdfq_seq.sv
module cdfq_seq #(
  parameter int MAX_LEN   = cdfq_pkg::MAX_LEN_DEF,
  parameter int DATA_BITS = cdfq_pkg::DATA_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  cdfq_pkg::seq_cmd_t               cmd,
  input  logic [$clog2(MAX_LEN+1)-1:0]     len,
  output cdfq_pkg::seq_stat_t              stat,
  output logic                             ln_re,
  output logic [$clog2(MAX_LEN)-1:0]       ln_raddr,
  input  logic [DATA_BITS-1:0]             ln_rdata,
  output logic                             res_we,
  output logic [$clog2(MAX_LEN)-1:0]       res_waddr,
  output logic [DATA_BITS-1:0]             res_wdata
);

  localparam int CW  = $clog2(MAX_LEN + 1);
  localparam int AW  = $clog2(MAX_LEN);
  localparam int AXW = CW + 1;
  localparam int W   = DATA_BITS + 2;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] F_CAP0  = 4'd1;
  localparam logic [3:0] F_CAPO  = 4'd2;
  localparam logic [3:0] F_H     = 4'd3;
  localparam logic [3:0] F_L     = 4'd4;
  localparam logic [3:0] F_Q     = 4'd5;
  localparam logic [3:0] I_CAPL  = 4'd6;
  localparam logic [3:0] I_E     = 4'd7;
  localparam logic [3:0] I_O     = 4'd8;
  localparam logic [3:0] I_LAST  = 4'd9;

  logic [3:0]    st_r, st_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] half_r;

  // forward window: x[2i], x[2i+1], x[2i+2], h[i], h[i-1]
  logic signed [W-1:0] xe_r, xo_r, xn_r, h_r, hp_r;
  // inverse: l[i], q[i], q[i-1], x[2i], x[2i-2]
  logic signed [W-1:0] l_r, qn_r, qp_r, x_r, xp_r;

  logic signed [W-1:0]         rdx;
  logic [AXW-1:0]              idx_x, half_x, raddr_w, waddr_w;
  logic                        last_i;
  logic                        done;
  cdfq_pkg::alu_op_t           alu_op;
  logic signed [W-1:0]         alu_a, alu_b, alu_c, alu_y;
  logic signed [DATA_BITS-1:0] alu_sat;

  assign rdx    = $signed({{2{ln_rdata[DATA_BITS-1]}}, ln_rdata});
  assign idx_x  = AXW'(idx_r);
  assign half_x = AXW'(half_r);
  assign last_i = (idx_r == half_r - CW'(1));

  cdfq_alu #(.DATA_BITS(DATA_BITS)) u_alu (
    .op    (alu_op),
    .a     (alu_a),
    .b     (alu_b),
    .c     (alu_c),
    .y     (alu_y),
    .y_sat (alu_sat)
  );

  always_comb begin
    st_nxt  = st_r;
    idx_nxt = idx_r;
    ln_re   = 1'b0;
    raddr_w = '0;
    res_we  = 1'b0;
    waddr_w = '0;
    done    = 1'b0;
    alu_op  = cdfq_pkg::OP_HI;
    alu_a   = '0;
    alu_b   = '0;
    alu_c   = '0;
    unique case (st_r)
      S_IDLE: begin
        if (cmd.start) begin
          ln_re   = 1'b1;
          idx_nxt = '0;
          st_nxt  = cmd.inverse ? I_CAPL : F_CAP0;
        end
      end
      F_CAP0: begin
        ln_re   = 1'b1;
        raddr_w = AXW'(1);
        st_nxt  = F_CAPO;
      end
      F_CAPO: begin
        ln_re   = 1'b1;
        raddr_w = (idx_x << 1) + AXW'(2);
        st_nxt  = F_H;
      end
      F_H: begin
        alu_op = cdfq_pkg::OP_HI;
        alu_a  = xo_r;
        alu_b  = xe_r;
        alu_c  = last_i ? xe_r : rdx;   // right edge: h = x[n-1] - x[n-2]
        st_nxt = F_L;
      end
      F_L: begin
        alu_op  = cdfq_pkg::OP_LO;
        alu_a   = xe_r;
        alu_b   = h_r;
        alu_c   = (idx_r == '0) ? h_r : hp_r;  // left edge uses h[0] twice
        res_we  = 1'b1;
        waddr_w = idx_x;
        st_nxt  = F_Q;
      end
      F_Q: begin
        alu_op  = cdfq_pkg::OP_QUANT;
        alu_a   = h_r;
        res_we  = 1'b1;
        waddr_w = half_x + idx_x;
        if (last_i) begin
          done   = 1'b1;
          st_nxt = S_IDLE;
        end else begin
          ln_re   = 1'b1;
          raddr_w = (idx_x << 1) + AXW'(3);
          idx_nxt = idx_r + CW'(1);
          st_nxt  = F_CAPO;
        end
      end
      I_CAPL: begin
        ln_re   = 1'b1;
        raddr_w = half_x + idx_x;
        st_nxt  = I_E;
      end
      I_E: begin
        alu_op  = cdfq_pkg::OP_HI;
        alu_a   = l_r;
        alu_b   = rdx;
        alu_c   = (idx_r == '0) ? rdx : qp_r;
        res_we  = 1'b1;
        waddr_w = idx_x << 1;
        st_nxt  = I_O;
      end
      I_O: begin
        alu_op  = cdfq_pkg::OP_ODD;
        alu_a   = qp_r;
        alu_b   = x_r;
        alu_c   = xp_r;
        res_we  = (idx_r != '0);
        waddr_w = (idx_x << 1) - AXW'(1);
        if (last_i) begin
          st_nxt = I_LAST;
        end else begin
          ln_re   = 1'b1;
          raddr_w = idx_x + AXW'(1);
          idx_nxt = idx_r + CW'(1);
          st_nxt  = I_CAPL;
        end
      end
      I_LAST: begin
        alu_op  = cdfq_pkg::OP_ODD;
        alu_a   = qp_r;
        alu_b   = xp_r;
        alu_c   = xp_r;
        res_we  = 1'b1;
        waddr_w = (half_x << 1) - AXW'(1);
        done    = 1'b1;
        st_nxt  = S_IDLE;
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  assign ln_raddr  = raddr_w[AW-1:0];
  assign res_waddr = waddr_w[AW-1:0];
  assign res_wdata = alu_sat;
  assign stat.busy = (st_r != S_IDLE);
  assign stat.done = done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      idx_r <= '0;
    end else begin
      st_r  <= st_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      S_IDLE: begin
        if (cmd.start) begin
          half_r <= len >> 1;
        end
      end
      F_CAP0: xe_r <= rdx;
      F_CAPO: xo_r <= rdx;
      F_H: begin
        xn_r <= rdx;
        h_r  <= alu_y;
      end
      F_Q: begin
        hp_r <= h_r;
        xe_r <= xn_r;
      end
      I_CAPL: l_r <= rdx;
      I_E: begin
        x_r  <= alu_y;
        qn_r <= rdx;
      end
      I_O: begin
        qp_r <= qn_r;
        xp_r <= x_r;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> hw/rtl/cdf22_lifting_wavelet_quantized.sv
// One-level CDF 2,2 (5/3) lifting wavelet over a line of values, with the
// high band quantized by two. A line of n values (line_length rounded down
// to even, held between 4 and MAX_LEN) is loaded one transaction per cycle,
// while in_stall is low, into the line memory; the transaction that completes
// the line starts the computation. Forward (direction 0): samples in, low
// band then high band out, high band divided by 2 toward zero. Inverse
// (direction 1): low band then high band in, rebuilt samples out, high band
// doubled on the way back. Every result saturates to the signed DATA_BITS
// range and the last result of a line has out_last set. The pace is set by
// the one read port of the line memory, the one shared ALU that the
// sequencer steps through each lifting update, and the registered read of
// the result memory; while draining, a new result read waits until the
// previous one has reached the output register. in_stall is high from the
// completing transaction until the last result has been read out to the
// output register; the output register lets loading of the next line overlap
// the final out_stall. Configuration writes are taken on any cycle but must
// only change while no line is being computed or drained.
module cdf22_lifting_wavelet_quantized #(
  parameter int MAX_LEN   = cdfq_pkg::MAX_LEN_DEF,
  parameter int DATA_BITS = cdfq_pkg::DATA_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [DATA_BITS-1:0]           in_value,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [DATA_BITS-1:0]           out_value_res,
  output logic                                  out_last,
  // configuration
  input  logic                                  cfg_we,
  input  logic [cdfq_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [cdfq_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int AW = $clog2(MAX_LEN);
  localparam int LB = cdfq_pkg::LEN_BITS;

  localparam logic [LB-1:0] LEN_CAP = LB'(MAX_LEN - (MAX_LEN % 2));

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_CALC  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  // configuration registers
  logic          direction_r;
  logic [LB-1:0] line_length_r;

  // control
  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] load_cnt_r, load_cnt_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic          rd_pend_r, rd_pend_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic signed [DATA_BITS-1:0] out_value_res_r;
  logic          out_last_r;

  logic          in_take, out_take, out_free, drain_issue, line_done;
  logic [LB-1:0] len_even, n_eff, cnt_inc;

  cdfq_pkg::seq_cmd_t  seq_cmd;
  cdfq_pkg::seq_stat_t seq_stat;

  logic                 ln_re;
  logic [AW-1:0]        ln_raddr;
  logic [DATA_BITS-1:0] ln_rdata;
  logic                 res_we;
  logic [AW-1:0]        res_waddr;
  logic [DATA_BITS-1:0] res_wdata;
  logic [DATA_BITS-1:0] res_rdata;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r   <= 1'b0;
      line_length_r <= cdfq_pkg::LINE_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cdfq_pkg::CFG_DIRECTION:   direction_r   <= cfg_data[0];
        cdfq_pkg::CFG_LINE_LENGTH: line_length_r <= cfg_data[LB-1:0];
      endcase
    end
  end

  // effective line length: even, clamped to [4, MAX_LEN]
  assign len_even = {line_length_r[LB-1:1], 1'b0};
  always_comb begin
    priority if (len_even < cdfq_pkg::LEN_MIN) begin
      n_eff = cdfq_pkg::LEN_MIN;
    end else if (len_even > LEN_CAP) begin
      n_eff = LEN_CAP;
    end else begin
      n_eff = len_even;
    end
  end

  assign in_stall  = (state_r != ST_LOAD);
  assign in_take   = in_valid && !in_stall;
  assign cnt_inc   = LB'(load_cnt_r) + LB'(1);
  // a shortened length takes effect at once: the next value closes the line
  assign line_done = in_take && (cnt_inc >= n_eff);

  assign out_take    = out_valid_r && !out_stall;
  assign out_free    = !out_valid_r || !out_stall;
  assign drain_issue = (state_r == ST_DRAIN) && !rd_pend_r && out_free && (k_r != n_r);

  assign seq_cmd.start   = line_done;
  assign seq_cmd.inverse = direction_r;

  always_comb begin
    state_nxt     = state_r;
    load_cnt_nxt  = load_cnt_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    rd_pend_nxt   = drain_issue;
    out_valid_nxt = out_take ? 1'b0 : out_valid_r;
    if (rd_pend_r) begin
      out_valid_nxt = 1'b1;
    end
    unique case (state_r)
      ST_LOAD: begin
        if (line_done) begin
          load_cnt_nxt = '0;
          n_nxt        = n_eff[CW-1:0];
          state_nxt    = ST_CALC;
        end else if (in_take) begin
          load_cnt_nxt = load_cnt_r + CW'(1);
        end
      end
      ST_CALC: begin
        if (seq_stat.done) begin
          k_nxt     = '0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_issue) begin
          k_nxt = k_r + CW'(1);
        end
        if (rd_pend_r && (k_r == n_r)) begin
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      load_cnt_r  <= '0;
      n_r         <= '0;
      k_r         <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      load_cnt_r  <= load_cnt_nxt;
      n_r         <= n_nxt;
      k_r         <= k_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output register, loaded from the result memory in the cycle after the read
  always_ff @(posedge clk) begin
    if (rd_pend_r) begin
      out_value_res_r <= $signed(res_rdata);
      out_last_r      <= (k_r == n_r);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_value_res = out_value_res_r;
  assign out_last      = out_last_r;

  cdfq_ram #(.WIDTH(DATA_BITS), .DEPTH(MAX_LEN)) u_line_ram (
    .clk   (clk),
    .we    (in_take),
    .waddr (load_cnt_r[AW-1:0]),
    .wdata (in_value),
    .re    (ln_re),
    .raddr (ln_raddr),
    .rdata (ln_rdata)
  );

  cdfq_ram #(.WIDTH(DATA_BITS), .DEPTH(MAX_LEN)) u_res_ram (
    .clk   (clk),
    .we    (res_we),
    .waddr (res_waddr),
    .wdata (res_wdata),
    .re    (drain_issue),
    .raddr (k_r[AW-1:0]),
    .rdata (res_rdata)
  );

  cdfq_seq #(.MAX_LEN(MAX_LEN), .DATA_BITS(DATA_BITS)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (seq_cmd),
    .len       (n_eff[CW-1:0]),
    .stat      (seq_stat),
    .ln_re     (ln_re),
    .ln_raddr  (ln_raddr),
    .ln_rdata  (ln_rdata),
    .res_we    (res_we),
    .res_waddr (res_waddr),
    .res_wdata (res_wdata)
  );

  // a drain read never lands on a result still waiting downstream
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> !out_valid_r)
    else $error("result memory read returned while output register full");

  // the sequencer only runs while the top level waits for it
  a_seq_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    seq_stat.busy |-> (state_r == ST_CALC))
    else $error("sequencer busy outside compute phase");

  a_drain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> (k_r <= n_r))
    else $error("drain index past line length");

  a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |-> (load_cnt_r < CW'(MAX_LEN)))
    else $error("line memory write past its depth");

  // a line start always follows a fully loaded line and leaves the counter at zero
  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    line_done |=> (load_cnt_r == '0) && (state_r == ST_CALC))
    else $error("line start did not clear the load count");

endmodule
